>>> rtl/bfa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// shared constants, codes, types and helper functions of the first-fit
// bitmap allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int WORD_BITS     = 64;
  localparam int BIT_W         = 6;
  localparam int ROW_WORDS     = 64;
  localparam int SLOT_W        = 6;
  localparam int MAX_WORDS_DEF = 1024;
  localparam int CFG_W         = 11;
  localparam int IDX_W         = 16;
  localparam int STATUS_W      = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLAG,
    S_WORD,
    S_FREE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

  // ones for positions base+j that lie below limit
  function automatic logic [ROW_WORDS-1:0] therm_mask(input logic [31:0] limit,
                                                      input logic [31:0] base);
    logic [31:0]          d;
    logic [ROW_WORDS-1:0] m;
    d = limit - base;
    if (limit <= base) begin
      m = '0;
    end else if (d >= 32'(ROW_WORDS)) begin
      m = '1;
    end else begin
      m = ~({ROW_WORDS{1'b1}} << d[SLOT_W-1:0]);
    end
    return m;
  endfunction

  // position of the lowest set bit
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bfa_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_in_if
// request channel: opcode and index to release, valid/ready handshake
// ----------------------------------------------------------------------------
interface bfa_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [bfa_pkg::IDX_W-1:0] free_index;

  modport source (output valid, output opcode, output free_index, input ready);
  modport sink   (input valid, input opcode, input free_index, output ready);
endinterface
`default_nettype wire

>>> rtl/bfa_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_out_if
// result channel: status and allocated index, valid/ready handshake
// ----------------------------------------------------------------------------
interface bfa_out_if;
  logic                         valid;
  logic                         ready;
  logic [bfa_pkg::STATUS_W-1:0] status;
  logic [bfa_pkg::IDX_W-1:0]    alloc_index;

  modport source (output valid, output status, output alloc_index, input ready);
  modport sink   (input valid, input status, input alloc_index, output ready);
endinterface
`default_nettype wire

>>> rtl/bitmap_first_fit_allocator_unit.sv
`default_nettype none
// allocate: row search, flag row read, word read-modify-write, result; free: word and flag read, clear, result
// invalid free or full with no open row: straight to result; full in part-used row: after flag read
// an allocate result is set by the flag and word reads, then loaded into the output register
// a new request is taken only in idle, also while an earlier result still waits in the output register
// reset: synchronous, words_in_use returns to 1024, every bit reads free at once
// (a high water mark stands in for clearing the memories, no clearing pass)
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_unit
// first-fit bitmap allocator over 64-bit words with word-full flags and a
// row summary that steers the search
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_unit #(
  parameter  int MAX_WORDS = bfa_pkg::MAX_WORDS_DEF,
  localparam int NW        = $clog2(MAX_WORDS + 1),
  localparam int AW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
  localparam int NROWS     = (MAX_WORDS + bfa_pkg::ROW_WORDS - 1) / bfa_pkg::ROW_WORDS,
  localparam int RW        = (NROWS > 1) ? $clog2(NROWS) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  bfa_in_if.sink                    in_ch,
  bfa_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [bfa_pkg::CFG_W-1:0] cfg_wdata
);

  logic [bfa_pkg::CFG_W-1:0]     words_in_use_r;
  logic [NW-1:0]                 n_words;
  logic [NW-1:0]                 hwm;
  bfa_pkg::mem_cmd_t             word_cmd;
  logic [AW-1:0]                 word_addr;
  logic [bfa_pkg::WORD_BITS-1:0] word_wdata;
  logic [bfa_pkg::WORD_BITS-1:0] word_rdata;
  bfa_pkg::mem_cmd_t             flag_cmd;
  logic [RW-1:0]                 flag_row;
  logic [bfa_pkg::ROW_WORDS-1:0] flag_wdata;
  logic [bfa_pkg::ROW_WORDS-1:0] flag_rdata;
  logic                          srch_found;
  logic [RW-1:0]                 srch_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_in_use_r <= bfa_pkg::CFG_RESET;
    end else if (cfg_we) begin
      words_in_use_r <= cfg_wdata;
    end
  end

  // saturate at the store depth
  assign n_words = (32'(words_in_use_r) > 32'(MAX_WORDS)) ? NW'(MAX_WORDS)
                                                          : NW'(words_in_use_r);

  bfa_ctrl #(.MAX_WORDS(MAX_WORDS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .n_words    (n_words),
    .word_cmd   (word_cmd),
    .word_addr  (word_addr),
    .word_wdata (word_wdata),
    .word_rdata (word_rdata),
    .flag_cmd   (flag_cmd),
    .flag_row   (flag_row),
    .flag_wdata (flag_wdata),
    .flag_rdata (flag_rdata),
    .srch_found (srch_found),
    .srch_row   (srch_row),
    .hwm        (hwm)
  );

  bfa_word_store #(.MAX_WORDS(MAX_WORDS)) u_word_store (
    .clk   (clk),
    .cmd   (word_cmd),
    .addr  (word_addr),
    .wdata (word_wdata),
    .hwm   (hwm),
    .rdata (word_rdata)
  );

  bfa_flag_store #(.MAX_WORDS(MAX_WORDS)) u_flag_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (flag_cmd),
    .row        (flag_row),
    .wdata      (flag_wdata),
    .hwm        (hwm),
    .n_words    (n_words),
    .rdata      (flag_rdata),
    .srch_found (srch_found),
    .srch_row   (srch_row)
  );

  // a taken request always leaves idle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request taken but block still idle");

  // only an ok allocation carries an index
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != bfa_pkg::ST_OK) |-> (out_ch.alloc_index == '0))
    else $error("non-ok result with non-zero index");

  // high water mark never falls back
  a_hwm_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (hwm >= $past(hwm)))
    else $error("high water mark decreased");

  // high water mark stays within the store
  a_hwm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(hwm) <= 32'(MAX_WORDS))
    else $error("high water mark beyond store depth");

endmodule
`default_nettype wire

>>> rtl/bfa_word_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_word_store
// bitmap word memory with a registered read; words at or above the high
// water mark have never been written and read as all free
// ----------------------------------------------------------------------------
module bfa_word_store #(
  parameter  int MAX_WORDS = bfa_pkg::MAX_WORDS_DEF,
  localparam int NW        = $clog2(MAX_WORDS + 1),
  localparam int AW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
  input  logic                            clk,
  input  bfa_pkg::mem_cmd_t               cmd,
  input  logic [AW-1:0]                   addr,
  input  logic [bfa_pkg::WORD_BITS-1:0]   wdata,
  input  logic [NW-1:0]                   hwm,
  output logic [bfa_pkg::WORD_BITS-1:0]   rdata
);

  logic [bfa_pkg::WORD_BITS-1:0] word_mem [MAX_WORDS];
  logic [bfa_pkg::WORD_BITS-1:0] rdata_r;
  logic [AW-1:0]                 raddr_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      word_mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= word_mem[addr];
      raddr_r <= addr;
    end
  end

  assign rdata = (32'(raddr_r) < 32'(hwm)) ? rdata_r : '0;

endmodule
`default_nettype wire

>>> rtl/bfa_flag_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_flag_store
// word-full flags kept as rows of 64 in a memory, plus one row-full summary
// bit per row that feeds the first non-full row search
// ----------------------------------------------------------------------------
module bfa_flag_store #(
  parameter  int MAX_WORDS = bfa_pkg::MAX_WORDS_DEF,
  localparam int NW        = $clog2(MAX_WORDS + 1),
  localparam int NROWS     = (MAX_WORDS + bfa_pkg::ROW_WORDS - 1) / bfa_pkg::ROW_WORDS,
  localparam int RW        = (NROWS > 1) ? $clog2(NROWS) : 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bfa_pkg::mem_cmd_t               cmd,
  input  logic [RW-1:0]                   row,
  input  logic [bfa_pkg::ROW_WORDS-1:0]   wdata,
  input  logic [NW-1:0]                   hwm,
  input  logic [NW-1:0]                   n_words,
  output logic [bfa_pkg::ROW_WORDS-1:0]   rdata,
  output logic                            srch_found,
  output logic [RW-1:0]                   srch_row
);

  logic [bfa_pkg::ROW_WORDS-1:0] flag_mem [NROWS];
  logic [bfa_pkg::ROW_WORDS-1:0] rdata_r;
  logic [RW-1:0]                 rrow_r;
  logic [NROWS-1:0]              summary_r;
  logic [NROWS-1:0]              cand;
  logic [31:0]                   rows_act;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      flag_mem[row] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= flag_mem[row];
      rrow_r  <= row;
    end
  end

  // row is skipped once every word in it is full
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      summary_r <= '0;
    end else if (cmd.wr) begin
      summary_r[row] <= &wdata;
    end
  end

  // flags of never written words read as not full
  assign rdata = rdata_r & bfa_pkg::therm_mask(32'(hwm), 32'(rrow_r) << bfa_pkg::SLOT_W);

  assign rows_act = (32'(n_words) + 32'(bfa_pkg::ROW_WORDS - 1)) >> bfa_pkg::SLOT_W;

  always_comb begin
    for (int r = 0; r < NROWS; r++) begin
      cand[r] = !summary_r[r] && (32'(r) < rows_act);
    end
  end

  always_comb begin
    srch_row = '0;
    for (int r = NROWS - 1; r >= 0; r--) begin
      if (cand[r]) begin
        srch_row = RW'(r);
      end
    end
  end

  assign srch_found = |cand;

endmodule
`default_nettype wire

>>> rtl/bfa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ctrl
// request sequencer: row search, flag row read, word read-modify-write,
// free path, high water mark and the result register
// ----------------------------------------------------------------------------
module bfa_ctrl #(
  parameter  int MAX_WORDS = bfa_pkg::MAX_WORDS_DEF,
  localparam int NW        = $clog2(MAX_WORDS + 1),
  localparam int AW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1,
  localparam int NROWS     = (MAX_WORDS + bfa_pkg::ROW_WORDS - 1) / bfa_pkg::ROW_WORDS,
  localparam int RW        = (NROWS > 1) ? $clog2(NROWS) : 1,
  localparam int WIW       = RW + bfa_pkg::SLOT_W
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bfa_in_if.sink                          in_ch,
  bfa_out_if.source                       out_ch,
  input  logic [NW-1:0]                   n_words,
  output bfa_pkg::mem_cmd_t               word_cmd,
  output logic [AW-1:0]                   word_addr,
  output logic [bfa_pkg::WORD_BITS-1:0]   word_wdata,
  input  logic [bfa_pkg::WORD_BITS-1:0]   word_rdata,
  output bfa_pkg::mem_cmd_t               flag_cmd,
  output logic [RW-1:0]                   flag_row,
  output logic [bfa_pkg::ROW_WORDS-1:0]   flag_wdata,
  input  logic [bfa_pkg::ROW_WORDS-1:0]   flag_rdata,
  input  logic                            srch_found,
  input  logic [RW-1:0]                   srch_row,
  output logic [NW-1:0]                   hwm
);

  bfa_pkg::state_t             state_r, state_nxt;
  logic [WIW-1:0]              w_r, w_nxt;
  logic [bfa_pkg::BIT_W-1:0]   bit_r, bit_nxt;
  logic [NW-1:0]               hwm_r, hwm_nxt;
  bfa_pkg::status_t            res_status_r, res_status_nxt;
  logic [bfa_pkg::IDX_W-1:0]   res_index_r, res_index_nxt;
  logic                        out_valid_r;
  bfa_pkg::status_t            out_status_r;
  logic [bfa_pkg::IDX_W-1:0]   out_index_r;

  logic                        in_acc;
  logic                        is_alloc;
  logic                        free_ok;
  logic                        load_out;
  logic [bfa_pkg::ROW_WORDS-1:0] nmask;
  logic [bfa_pkg::ROW_WORDS-1:0] cand;
  logic                        cand_any;
  logic [bfa_pkg::SLOT_W-1:0]  slot;
  logic [bfa_pkg::BIT_W-1:0]   alloc_bit;
  logic [bfa_pkg::WORD_BITS-1:0] set_word;
  logic [bfa_pkg::WORD_BITS-1:0] clr_word;
  logic [31:0]                 w_plus1;

  assign in_ch.ready = (state_r == bfa_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_alloc    = (in_ch.opcode == bfa_pkg::OP_ALLOC);
  assign free_ok     = 32'(in_ch.free_index >> bfa_pkg::BIT_W) < 32'(n_words);
  assign load_out    = (state_r == bfa_pkg::S_RESP) && (!out_valid_r || out_ch.ready);

  // datapath
  assign nmask    = bfa_pkg::therm_mask(32'(n_words),
                                        32'(w_r[WIW-1:bfa_pkg::SLOT_W]) << bfa_pkg::SLOT_W);
  assign cand     = ~flag_rdata & nmask;
  assign cand_any = |cand;
  assign slot     = bfa_pkg::lowest_set(cand);

  assign alloc_bit = bfa_pkg::lowest_set(~word_rdata);
  assign set_word  = word_rdata | (64'b1 << alloc_bit);
  assign clr_word  = word_rdata & ~(64'b1 << bit_r);
  assign w_plus1   = 32'(w_r) + 32'd1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfa_pkg::S_IDLE: begin
        if (in_acc) begin
          if (is_alloc) begin
            state_nxt = srch_found ? bfa_pkg::S_FLAG : bfa_pkg::S_RESP;
          end else begin
            state_nxt = free_ok ? bfa_pkg::S_FREE : bfa_pkg::S_RESP;
          end
        end
      end
      bfa_pkg::S_FLAG: begin
        state_nxt = cand_any ? bfa_pkg::S_WORD : bfa_pkg::S_RESP;
      end
      bfa_pkg::S_WORD: state_nxt = bfa_pkg::S_RESP;
      bfa_pkg::S_FREE: state_nxt = bfa_pkg::S_RESP;
      bfa_pkg::S_RESP: begin
        if (load_out) begin
          state_nxt = bfa_pkg::S_IDLE;
        end
      end
      default: state_nxt = bfa_pkg::S_IDLE;
    endcase
  end

  // outputs and register updates
  always_comb begin
    word_cmd       = '0;
    word_addr      = AW'(w_r);
    word_wdata     = set_word;
    flag_cmd       = '0;
    flag_row       = RW'(w_r >> bfa_pkg::SLOT_W);
    flag_wdata     = flag_rdata;
    w_nxt          = w_r;
    bit_nxt        = bit_r;
    hwm_nxt        = hwm_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    case (state_r)
      bfa_pkg::S_IDLE: begin
        if (in_acc) begin
          res_index_nxt = '0;
          if (is_alloc) begin
            res_status_nxt = bfa_pkg::ST_FULL;
            w_nxt          = {srch_row, {bfa_pkg::SLOT_W{1'b0}}};
            flag_cmd.rd    = srch_found;
            flag_row       = srch_row;
          end else begin
            res_status_nxt = free_ok ? bfa_pkg::ST_OK : bfa_pkg::ST_INVALID;
            w_nxt          = WIW'(in_ch.free_index >> bfa_pkg::BIT_W);
            bit_nxt        = in_ch.free_index[bfa_pkg::BIT_W-1:0];
            word_cmd.rd    = free_ok;
            word_addr      = AW'(in_ch.free_index >> bfa_pkg::BIT_W);
            flag_cmd.rd    = free_ok;
            flag_row       = RW'(in_ch.free_index >> (bfa_pkg::BIT_W + bfa_pkg::SLOT_W));
          end
        end
      end
      bfa_pkg::S_FLAG: begin
        w_nxt       = {w_r[WIW-1:bfa_pkg::SLOT_W], slot};
        word_cmd.rd = cand_any;
        word_addr   = AW'({w_r[WIW-1:bfa_pkg::SLOT_W], slot});
      end
      bfa_pkg::S_WORD: begin
        word_cmd.wr    = 1'b1;
        word_wdata     = set_word;
        flag_cmd.wr    = 1'b1;
        flag_wdata     = flag_rdata |
                         (64'(&set_word) << w_r[bfa_pkg::SLOT_W-1:0]);
        res_status_nxt = bfa_pkg::ST_OK;
        res_index_nxt  = bfa_pkg::IDX_W'({w_r, alloc_bit});
        if (w_plus1 > 32'(hwm_r)) begin
          hwm_nxt = NW'(w_plus1);
        end
      end
      bfa_pkg::S_FREE: begin
        word_cmd.wr = 1'b1;
        word_wdata  = clr_word;
        flag_cmd.wr = 1'b1;
        flag_wdata  = flag_rdata & ~(64'b1 << w_r[bfa_pkg::SLOT_W-1:0]);
      end
      bfa_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfa_pkg::S_IDLE;
      hwm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hwm_r   <= hwm_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    bit_r        <= bit_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    if (load_out) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.alloc_index = out_index_r;
  assign hwm                = hwm_r;

endmodule
`default_nettype wire

>>> tb/sv/bitmap_first_fit_allocator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator_unit_tb
// allocate and free requests with random gaps and result stalls, checked
// against a shadow bitmap; words in use changed between phases while idle
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator_unit_tb;

  localparam int NWORDS     = 1024;
  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE     = 8;
  localparam int RAND_ITEMS = 1700;

  typedef struct {
    bfa_pkg::opcode_t          op;
    logic [bfa_pkg::IDX_W-1:0] index;
  } request_t;

  typedef struct {
    bfa_pkg::opcode_t          op;
    bfa_pkg::status_t          status;
    logic [bfa_pkg::IDX_W-1:0] alloc_index;
  } answer_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [bfa_pkg::CFG_W-1:0] cfg_wdata;

  bfa_in_if  in_ch ();
  bfa_out_if out_ch ();

  bitmap_first_fit_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  logic [bfa_pkg::WORD_BITS-1:0] shadow_map [NWORDS];
  logic [bfa_pkg::CFG_W-1:0]     shadow_words;

  request_t request_queue [$];
  answer_t  awaited_answers [$];

  request_t drv_req;
  int       in_gap;
  int       in_gap_max;
  int       out_stall;
  int       out_stall_max;
  int       stall_draw;
  int       idle_cycles;
  int       fail_count;
  int       n_alloc_ok;
  int       n_full;
  int       n_invalid;
  int       n_free_ok;
  int       n_phases;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow of the allocator: one answer per request
  task automatic compute_answer(input request_t r);
    int      n;
    int      w;
    int      b;
    answer_t a;
    n = (shadow_words > NWORDS) ? NWORDS : int'(shadow_words);
    a.op          = r.op;
    a.status      = bfa_pkg::ST_FULL;
    a.alloc_index = '0;
    if (r.op == bfa_pkg::OP_ALLOC) begin
      for (w = 0; w < n && a.status == bfa_pkg::ST_FULL; w++) begin
        if (shadow_map[w] != '1) begin
          for (b = 0; shadow_map[w][b]; b++) ;
          shadow_map[w][b] = 1'b1;
          a.status         = bfa_pkg::ST_OK;
          a.alloc_index    = bfa_pkg::IDX_W'(w * bfa_pkg::WORD_BITS + b);
        end
      end
    end else if (int'(r.index) >= n * bfa_pkg::WORD_BITS) begin
      a.status = bfa_pkg::ST_INVALID;
    end else begin
      shadow_map[r.index / bfa_pkg::WORD_BITS][r.index % bfa_pkg::WORD_BITS] = 1'b0;
      a.status = bfa_pkg::ST_OK;
    end
    awaited_answers.push_back(a);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap      <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        drv_req.op    = bfa_pkg::opcode_t'(in_ch.opcode);
        drv_req.index = in_ch.free_index;
        compute_answer(drv_req);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap      <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          drv_req          = request_queue.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.opcode     <= drv_req.op;
          in_ch.free_index <= drv_req.index;
          in_gap           <= $urandom_range(0, in_gap_max);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_answers.size() == 0) begin
          $error("result with no request outstanding: status %0d index %0d",
                 out_ch.status, out_ch.alloc_index);
          fail_count++;
        end else begin
          answer_t a;
          a = awaited_answers.pop_front();
          if (out_ch.status !== a.status) begin
            $error("status: expected %0d, got %0d", a.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.alloc_index !== a.alloc_index) begin
            $error("alloc_index: expected %0d, got %0d", a.alloc_index,
                   out_ch.alloc_index);
            fail_count++;
          end
          case (a.status)
            bfa_pkg::ST_FULL:    n_full++;
            bfa_pkg::ST_INVALID: n_invalid++;
            default: begin
              if (a.op == bfa_pkg::OP_ALLOC) n_alloc_ok++;
              else n_free_ok++;
            end
          endcase
        end
        stall_draw = $urandom_range(0, out_stall_max);
        out_stall    <= stall_draw;
        out_ch.ready <= (stall_draw == 0);
      end else if (out_stall > 0) begin
        out_stall    <= out_stall - 1;
        out_ch.ready <= (out_stall == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d requests still pending", awaited_answers.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_req(input bfa_pkg::opcode_t op, input int index);
    request_t r;
    r.op    = op;
    r.index = bfa_pkg::IDX_W'(index);
    request_queue.push_back(r);
  endtask

  // sampled mid-cycle so the driver's updates of this edge are visible
  task automatic settle();
    while (request_queue.size() != 0 || awaited_answers.size() != 0 || in_ch.valid)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_words(input int value);
    settle();
    @(posedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= bfa_pkg::CFG_W'(value);
    shadow_words = bfa_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    n_phases++;
  endtask

  function automatic int pick_free_index(input int cap);
    int low_span;
    if (cap == 0) return $urandom_range(0, 65535);
    low_span = (cap < 256) ? cap : 256;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, low_span - 1);
      5, 6:          return $urandom_range(0, cap - 1);
      7:             return cap - 1;
      8:             return cap;
      default:       return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_words();
    case ($urandom_range(0, 9))
      0:       return 0;
      1, 2:    return 1;
      3:       return $urandom_range(2, 4);
      4:       return 1024;
      5:       return 2047;
      6:       return $urandom_range(0, 1) ? 1023 : 1025;
      7:       return $urandom_range(1, 2047);
      default: return $urandom_range(5, 64);
    endcase
  endfunction

  initial begin
    int words;
    int cap;
    int len;
    int alloc_pct;
    int sent;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.opcode     = bfa_pkg::OP_ALLOC;
    in_ch.free_index = '0;
    out_ch.ready     = 1'b0;
    in_gap_max       = 0;
    out_stall_max    = 0;
    idle_cycles      = 0;
    fail_count       = 0;
    n_alloc_ok       = 0;
    n_full           = 0;
    n_invalid        = 0;
    n_free_ok        = 0;
    n_phases         = 0;
    sent             = 0;
    shadow_words     = bfa_pkg::CFG_RESET;
    foreach (shadow_map[i]) shadow_map[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset capacity: first fit, refill of a hole, free of a free bit, top index
    push_req(bfa_pkg::OP_ALLOC, 0);
    push_req(bfa_pkg::OP_ALLOC, 0);
    push_req(bfa_pkg::OP_ALLOC, 65535);
    push_req(bfa_pkg::OP_FREE, 1);
    push_req(bfa_pkg::OP_ALLOC, 0);
    push_req(bfa_pkg::OP_FREE, 1);
    push_req(bfa_pkg::OP_FREE, 1);
    push_req(bfa_pkg::OP_FREE, 65535);
    push_req(bfa_pkg::OP_ALLOC, 0);
    // no words in use
    write_words(0);
    push_req(bfa_pkg::OP_ALLOC, 0);
    push_req(bfa_pkg::OP_FREE, 0);
    // above the maximum, saturates
    write_words(2047);
    push_req(bfa_pkg::OP_FREE, 65535);
    push_req(bfa_pkg::OP_ALLOC, 0);
    // one word, free just past the end
    write_words(1);
    push_req(bfa_pkg::OP_FREE, 64);
    push_req(bfa_pkg::OP_FREE, 63);
    push_req(bfa_pkg::OP_ALLOC, 0);

    while (sent < RAND_ITEMS) begin
      words = (n_phases == 3) ? 1024 : pick_words();
      write_words(words);
      cap           = ((words > NWORDS) ? NWORDS : words) * bfa_pkg::WORD_BITS;
      in_gap_max    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      out_stall_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
      alloc_pct     = $urandom_range(20, 95);
      len           = $urandom_range(30, 120);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(1, 100) <= alloc_pct)
          push_req(bfa_pkg::OP_ALLOC, $urandom_range(0, 65535));
        else
          push_req(bfa_pkg::OP_FREE, pick_free_index(cap));
      end
      sent += len;
    end

    settle();
    repeat (20) @(posedge clk);
    $display("%0d config phases: %0d allocations granted, %0d frees ok",
             n_phases, n_alloc_ok, n_free_ok);
    $display("%0d full answers, %0d invalid frees, %0d mismatches",
             n_full, n_invalid, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
